// ===== src/axis_angle_rotation_matrix_defines.svh =====
// assertion macros shared by the rotation matrix block
`ifndef AXIS_ANGLE_ROTATION_MATRIX_DEFINES_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_DEFINES_SVH

// same-cycle implication, checked out of reset
`define AARM_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("aarm assertion failed");

// next-cycle implication, checked out of reset
`define AARM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("aarm assertion failed");

`endif

// ===== src/aarm_pkg.sv =====
// types, constants and helper functions of the rotation matrix block
`timescale 1ns / 1ps
package aarm_pkg;

    localparam int DEF_CORDIC_STAGES = 16;
    localparam int RED_W = 32;
    localparam int ANG_W = 35;
    localparam int CW = 33;
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 32;
    localparam int SUM_W = 53;

    localparam logic signed [ANG_W-1:0] PI_Q30 = 35'sd3373259426;
    localparam logic signed [ANG_W-1:0] NEG_PI_Q30 = -35'sd3373259426;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q30 = 35'sd6746518853;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [ANG_W-1:0] NEG_HALF_PI_Q30 = -35'sd1686629713;
    localparam logic signed [CW-1:0] GAIN_Q30 = 33'sd652032874;

    typedef struct packed {
        logic signed [RED_W-1:0] angle;
        logic flip;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
    } t_item;

    typedef struct packed {
        logic signed [17:0] m00;
        logic signed [17:0] m01;
        logic signed [17:0] m02;
        logic signed [17:0] m10;
        logic signed [17:0] m11;
        logic signed [17:0] m12;
        logic signed [17:0] m20;
        logic signed [17:0] m21;
        logic signed [17:0] m22;
    } t_matrix;

    // atan(2^-i) in Q30, truncated
    function automatic logic signed [CW-1:0] atan_q30(input int i);
        logic signed [CW-1:0] v;
        unique case (i)
            0: v = 33'sd843314856;
            1: v = 33'sd497837829;
            2: v = 33'sd263043836;
            3: v = 33'sd133525158;
            4: v = 33'sd67021686;
            5: v = 33'sd33543515;
            6: v = 33'sd16775850;
            7: v = 33'sd8388437;
            8: v = 33'sd4194282;
            9: v = 33'sd2097149;
            10: v = 33'sd1048575;
            11: v = 33'sd524287;
            12: v = 33'sd262143;
            13: v = 33'sd131071;
            14: v = 33'sd65535;
            15: v = 33'sd32767;
            16: v = 33'sd16383;
            17: v = 33'sd8191;
            18: v = 33'sd4095;
            19: v = 33'sd2047;
            20: v = 33'sd1023;
            21: v = 33'sd511;
            22: v = 33'sd255;
            23: v = 33'sd127;
            default: v = '0;
        endcase
        return v;
    endfunction

    // round half up from Q44 to Q14, then saturate to 18 bits
    function automatic logic signed [17:0] round_sat(input logic signed [SUM_W-1:0] e);
        logic signed [SUM_W-1:0] r;
        r = (e + SUM_W'(64'sd536870912)) >>> 30;
        if (r > SUM_W'(64'sd131071)) begin
            return 18'sd131071;
        end else if (r < -SUM_W'(64'sd131072)) begin
            return -18'sd131072;
        end
        return r[17:0];
    endfunction

endpackage

// ===== src/axis_angle_rotation_matrix.sv =====
// path from push to the result (empty low): mid queue, cordic input register, cordic stages, p1 to p5, output queue
// throughput: one transaction per cycle while credits remain, set by the fully pipelined cordic and multipliers
// the output queue holds 32 results; credits stop the back end before it can overflow
// reset: synchronous active-low i_rst_n empties both queues and clears pipeline valids
// no clearing pass; the block takes transactions in the cycle after reset
`timescale 1ns / 1ps
module axis_angle_rotation_matrix #(
    parameter int CORDIC_STAGES = aarm_pkg::DEF_CORDIC_STAGES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] i_angle,
    input  logic signed [15:0] i_axis_x,
    input  logic signed [15:0] i_axis_y,
    input  logic signed [15:0] i_axis_z,
    output logic               empty,
    input  logic               pop,
    output logic signed [17:0] o_m00,
    output logic signed [17:0] o_m01,
    output logic signed [17:0] o_m02,
    output logic signed [17:0] o_m10,
    output logic signed [17:0] o_m11,
    output logic signed [17:0] o_m12,
    output logic signed [17:0] o_m20,
    output logic signed [17:0] o_m21,
    output logic signed [17:0] o_m22
);
    import aarm_pkg::*;

    // front to mid queue
    logic   front_push;
    t_item  front_item;
    // mid queue to back end
    logic   mid_empty, mid_pop;
    t_item  mid_item;
    // back end to output queue
    logic   back_push, out_pop, out_full;
    t_matrix back_matrix, out_matrix;

    // front end reduces the angle and folds it into [-pi/2, pi/2]
    aarm_front u_front (
        .i_push   (push),
        .i_full   (full),
        .i_angle  (i_angle),
        .i_axis_x (i_axis_x),
        .i_axis_y (i_axis_y),
        .i_axis_z (i_axis_z),
        .o_push   (front_push),
        .o_item   (front_item)
    );

    // short queue decoupling front and back
    aarm_fifo #(
        .WIDTH ($bits(t_item)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_item),
        .o_full  (full),
        .i_pop   (mid_pop),
        .o_data  (mid_item),
        .o_empty (mid_empty)
    );

    // cordic and matrix arithmetic, never stalls once an item is taken
    aarm_back #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (mid_empty),
        .i_item    (mid_item),
        .o_pop     (mid_pop),
        .i_out_pop (out_pop),
        .o_push    (back_push),
        .o_matrix  (back_matrix)
    );

    // result queue; its head drives the output ports
    aarm_fifo #(
        .WIDTH ($bits(t_matrix)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_push),
        .i_data  (back_matrix),
        .o_full  (out_full),
        .i_pop   (out_pop),
        .o_data  (out_matrix),
        .o_empty (empty)
    );

    assign out_pop = pop && !empty;

    assign o_m00 = out_matrix.m00;
    assign o_m01 = out_matrix.m01;
    assign o_m02 = out_matrix.m02;
    assign o_m10 = out_matrix.m10;
    assign o_m11 = out_matrix.m11;
    assign o_m12 = out_matrix.m12;
    assign o_m20 = out_matrix.m20;
    assign o_m21 = out_matrix.m21;
    assign o_m22 = out_matrix.m22;

    `include "axis_angle_rotation_matrix_defines.svh"
    // credits must keep the result queue from ever overflowing
    `AARM_ASSERT(a_no_overflow, back_push, !out_full || out_pop)
endmodule

// ===== src/aarm_fifo.sv =====
// small register queue with combinational head read
`timescale 1ns / 1ps
module aarm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [AW:0] r_cnt, n_cnt;
    logic do_push, do_pop;

    assign o_full = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && !o_empty;

    always_comb begin
        n_wr = do_push ? r_wr + 1'b1 : r_wr;
        n_rd = do_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule

// ===== src/aarm_front.sv =====
// front end: angle reduction to the principal range and quadrant fold
`timescale 1ns / 1ps
module aarm_front (
    input  logic               i_push,
    input  logic               i_full,
    input  logic signed [15:0] i_angle,
    input  logic signed [15:0] i_axis_x,
    input  logic signed [15:0] i_axis_y,
    input  logic signed [15:0] i_axis_z,
    output logic               o_push,
    output aarm_pkg::t_item    o_item
);
    import aarm_pkg::*;

    logic signed [ANG_W-1:0] a0, a1, a2;
    logic flip;

    always_comb begin
        a0 = {{2{i_angle[15]}}, i_angle, 17'b0};
        if (a0 > PI_Q30) begin
            a1 = a0 - TWO_PI_Q30;
        end else if (a0 < NEG_PI_Q30) begin
            a1 = a0 + TWO_PI_Q30;
        end else begin
            a1 = a0;
        end
        flip = 1'b0;
        if (a1 > HALF_PI_Q30) begin
            a2 = a1 - PI_Q30;
            flip = 1'b1;
        end else if (a1 < NEG_HALF_PI_Q30) begin
            a2 = a1 + PI_Q30;
            flip = 1'b1;
        end else begin
            a2 = a1;
        end
    end

    assign o_push = i_push && !i_full;
    assign o_item.angle = a2[RED_W-1:0];
    assign o_item.flip = flip;
    assign o_item.ax = i_axis_x;
    assign o_item.ay = i_axis_y;
    assign o_item.az = i_axis_z;
endmodule

// ===== src/aarm_back.sv =====
// back end: pipelined cordic, multiplier array, rounding and credit control
`timescale 1ns / 1ps
module aarm_back #(
    parameter int CORDIC_STAGES = aarm_pkg::DEF_CORDIC_STAGES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  aarm_pkg::t_item   i_item,
    output logic              o_pop,
    input  logic              i_out_pop,
    output logic              o_push,
    output aarm_pkg::t_matrix o_matrix
);
    import aarm_pkg::*;
    `include "axis_angle_rotation_matrix_defines.svh"

    localparam int NS = CORDIC_STAGES;
    localparam int CRW = $clog2(OUT_DEPTH) + 1;

    // credits cover every result in flight or parked in the output queue
    logic [CRW-1:0] r_credit, n_credit;
    logic take;

    assign take = !i_empty && (r_credit < CRW'(OUT_DEPTH));
    assign o_pop = take;
    assign n_credit = r_credit + CRW'(take) - CRW'(i_out_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= n_credit;
        end
    end

    // cordic stages
    logic [NS:0] r_v;
    logic signed [CW-1:0] r_x [NS+1];
    logic signed [CW-1:0] r_y [NS+1];
    logic signed [CW-1:0] r_z [NS+1];
    logic r_f [NS+1];
    logic signed [15:0] r_ax [NS+1];
    logic signed [15:0] r_ay [NS+1];
    logic signed [15:0] r_az [NS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0] <= GAIN_Q30;
        r_y[0] <= '0;
        r_z[0] <= CW'(i_item.angle);
        r_f[0] <= i_item.flip;
        r_ax[0] <= i_item.ax;
        r_ay[0] <= i_item.ay;
        r_az[0] <= i_item.az;
    end

    for (genvar g = 0; g < NS; g++) begin : g_stage
        logic signed [CW-1:0] dx, dy;
        assign dx = r_y[g] >>> g;
        assign dy = r_x[g] >>> g;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else begin
                r_v[g+1] <= r_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!r_z[g][CW-1]) begin
                r_x[g+1] <= r_x[g] - dx;
                r_y[g+1] <= r_y[g] + dy;
                r_z[g+1] <= r_z[g] - atan_q30(g);
            end else begin
                r_x[g+1] <= r_x[g] + dx;
                r_y[g+1] <= r_y[g] - dy;
                r_z[g+1] <= r_z[g] + atan_q30(g);
            end
            r_f[g+1] <= r_f[g];
            r_ax[g+1] <= r_ax[g];
            r_ay[g+1] <= r_ay[g];
            r_az[g+1] <= r_az[g];
        end
    end

    // p1: fold back and round cosine and sine to Q16, and form 1 - c
    logic signed [CW-1:0] cxf, cyf, cxr, cyr;
    logic signed [17:0] r_c1, r_s1;
    logic signed [18:0] r_t1;
    logic signed [15:0] r_ax1, r_ay1, r_az1;
    logic [5:1] r_vp;

    always_comb begin
        cxf = r_f[NS] ? -r_x[NS] : r_x[NS];
        cyf = r_f[NS] ? -r_y[NS] : r_y[NS];
        cxr = (cxf + CW'(8192)) >>> 14;
        cyr = (cyf + CW'(8192)) >>> 14;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= '0;
        end else begin
            r_vp <= {r_vp[4:1], r_v[NS]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_c1 <= cxr[17:0];
        r_s1 <= cyr[17:0];
        r_t1 <= 19'sd65536 - 19'(cxr);
        r_ax1 <= r_ax[NS];
        r_ay1 <= r_ay[NS];
        r_az1 <= r_az[NS];
    end

    // p2: axis products and sine products
    logic signed [31:0] r_pxx, r_pxy, r_pxz, r_pyy, r_pyz, r_pzz;
    logic signed [33:0] r_sx, r_sy, r_sz;
    logic signed [17:0] r_c2;
    logic signed [18:0] r_t2;

    always_ff @(posedge i_clk) begin
        r_pxx <= r_ax1 * r_ax1;
        r_pxy <= r_ax1 * r_ay1;
        r_pxz <= r_ax1 * r_az1;
        r_pyy <= r_ay1 * r_ay1;
        r_pyz <= r_ay1 * r_az1;
        r_pzz <= r_az1 * r_az1;
        r_sx <= 34'(r_ax1) * 34'(r_s1);
        r_sy <= 34'(r_ay1) * 34'(r_s1);
        r_sz <= 34'(r_az1) * 34'(r_s1);
        r_c2 <= r_c1;
        r_t2 <= r_t1;
    end

    // p3: scale by 1 - c, align sine and cosine terms to Q44
    logic signed [SUM_W-1:0] r_qxx, r_qxy, r_qxz, r_qyy, r_qyz, r_qzz;
    logic signed [SUM_W-1:0] r_hx, r_hy, r_hz, r_hc;

    always_ff @(posedge i_clk) begin
        r_qxx <= SUM_W'(51'(r_pxx) * 51'(r_t2));
        r_qxy <= SUM_W'(51'(r_pxy) * 51'(r_t2));
        r_qxz <= SUM_W'(51'(r_pxz) * 51'(r_t2));
        r_qyy <= SUM_W'(51'(r_pyy) * 51'(r_t2));
        r_qyz <= SUM_W'(51'(r_pyz) * 51'(r_t2));
        r_qzz <= SUM_W'(51'(r_pzz) * 51'(r_t2));
        r_hx <= SUM_W'(r_sx) <<< 14;
        r_hy <= SUM_W'(r_sy) <<< 14;
        r_hz <= SUM_W'(r_sz) <<< 14;
        r_hc <= SUM_W'(r_c2) <<< 28;
    end

    // p4: exact entries in Q44
    logic signed [SUM_W-1:0] r_e [9];

    always_ff @(posedge i_clk) begin
        r_e[0] <= r_qxx + r_hc;
        r_e[1] <= r_qxy - r_hz;
        r_e[2] <= r_qxz + r_hy;
        r_e[3] <= r_qxy + r_hz;
        r_e[4] <= r_qyy + r_hc;
        r_e[5] <= r_qyz - r_hx;
        r_e[6] <= r_qxz - r_hy;
        r_e[7] <= r_qyz + r_hx;
        r_e[8] <= r_qzz + r_hc;
    end

    // p5: round and saturate
    always_ff @(posedge i_clk) begin
        o_matrix.m00 <= round_sat(r_e[0]);
        o_matrix.m01 <= round_sat(r_e[1]);
        o_matrix.m02 <= round_sat(r_e[2]);
        o_matrix.m10 <= round_sat(r_e[3]);
        o_matrix.m11 <= round_sat(r_e[4]);
        o_matrix.m12 <= round_sat(r_e[5]);
        o_matrix.m20 <= round_sat(r_e[6]);
        o_matrix.m21 <= round_sat(r_e[7]);
        o_matrix.m22 <= round_sat(r_e[8]);
    end

    assign o_push = r_vp[5];

    `AARM_ASSERT(a_credit_bound, 1'b1, r_credit <= CRW'(OUT_DEPTH))
    `AARM_ASSERT(a_push_has_credit, o_push, r_credit != '0)
    `AARM_ASSERT_NEXT(a_take_counts, take && !i_out_pop, r_credit == $past(r_credit) + 1'b1)
endmodule

// ===== dv/axis_angle_rotation_matrix_test.sv =====
// testbench for the axis-angle rotation matrix block with a cycle-free predictor
`timescale 1ns / 1ps
module axis_angle_rotation_matrix_test;

    import aarm_pkg::*;

    localparam int N_RANDOM = 1500;
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 64;

    typedef struct packed {
        logic signed [15:0] angle;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
    } t_rot_req;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic signed [15:0] i_angle = '0;
    logic signed [15:0] i_axis_x = '0;
    logic signed [15:0] i_axis_y = '0;
    logic signed [15:0] i_axis_z = '0;
    logic full;
    logic empty;
    logic signed [17:0] o_m00, o_m01, o_m02, o_m10, o_m11, o_m12, o_m20, o_m21, o_m22;

    // pending requests for the driver, expected matrices for the monitor
    t_rot_req req_queue[$];
    t_matrix matrix_queue[$];
    int n_errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int quiet_cycles = 0;
    bit calm_phase = 1'b0;
    bit hold_push = 1'b0;
    int push_gap = 0;
    int pop_gap = 0;

    always #5 i_clk = ~i_clk;

    axis_angle_rotation_matrix DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_angle (i_angle),
        .i_axis_x(i_axis_x),
        .i_axis_y(i_axis_y),
        .i_axis_z(i_axis_z),
        .empty   (empty),
        .pop     (pop),
        .o_m00   (o_m00),
        .o_m01   (o_m01),
        .o_m02   (o_m02),
        .o_m10   (o_m10),
        .o_m11   (o_m11),
        .o_m12   (o_m12),
        .o_m20   (o_m20),
        .o_m21   (o_m21),
        .o_m22   (o_m22)
    );

    // floor division by 2^k
    function automatic longint floor_shift(input longint v, input int k);
        return v >>> k;
    endfunction

    // Q44 entry rounded half up to Q14 and clamped to 18 bits
    function automatic logic signed [17:0] q44_to_entry(input longint e);
        longint r;
        r = (e + (64'sd1 <<< 29)) >>> 30;
        if (r > 131071) r = 131071;
        if (r < -131072) r = -131072;
        return r[17:0];
    endfunction

    // cosine/sine via cordic, then the 3x3 rotation block
    function automatic t_matrix rotation_matrix(input t_rot_req rq);
        longint ang, x, y, dx, dy, c, s, t, sc, ax, ay, az, one_c;
        longint atan_tab[24];
        bit flip;
        t_matrix m;
        atan_tab = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                     16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
                     131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};
        ang = longint'(rq.angle) * 131072;
        ax = rq.ax;
        ay = rq.ay;
        az = rq.az;
        x = 652032874;
        y = 0;
        flip = 1'b0;
        // principal range, then fold into +-pi/2
        if (ang > 64'sd3373259426) ang -= 64'sd6746518853;
        if (ang < -64'sd3373259426) ang += 64'sd6746518853;
        if (ang > 64'sd1686629713) begin
            ang -= 64'sd3373259426;
            flip = 1'b1;
        end else if (ang < -64'sd1686629713) begin
            ang += 64'sd3373259426;
            flip = 1'b1;
        end
        for (int i = 0; i < DEF_CORDIC_STAGES && i < 24; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (ang >= 0) begin
                x -= dx;
                y += dy;
                ang -= atan_tab[i];
            end else begin
                x += dx;
                y -= dy;
                ang += atan_tab[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = floor_shift(x + 8192, 14);
        s = floor_shift(y + 8192, 14);
        t = 65536 - c;
        sc = 16384;
        one_c = c * (64'sd1 <<< 28);
        m.m00 = q44_to_entry(ax * ax * t + one_c);
        m.m01 = q44_to_entry(ax * ay * t - az * s * sc);
        m.m02 = q44_to_entry(ax * az * t + ay * s * sc);
        m.m10 = q44_to_entry(ay * ax * t + az * s * sc);
        m.m11 = q44_to_entry(ay * ay * t + one_c);
        m.m12 = q44_to_entry(ay * az * t - ax * s * sc);
        m.m20 = q44_to_entry(ax * az * t - ay * s * sc);
        m.m21 = q44_to_entry(ay * az * t + ax * s * sc);
        m.m22 = q44_to_entry(az * az * t + one_c);
        return m;
    endfunction

    task automatic report_mismatch(input string field, input logic signed [17:0] got,
                                   input logic signed [17:0] want);
        n_errors++;
        $display("mismatch at %0t: %s got %0d want %0d", $time, field, got, want);
    endtask

    function automatic t_rot_req make_req(input int a, input int x, input int y, input int z);
        t_rot_req rq;
        rq.angle = a[15:0];
        rq.ax = x[15:0];
        rq.ay = y[15:0];
        rq.az = z[15:0];
        return rq;
    endfunction

    // unit axes, short axes with components in [-9459, 9459], and some arbitrary 16-bit noise
    function automatic t_rot_req random_req();
        int sel;
        int comp[3];
        sel = $urandom_range(0, 9);
        if (sel < 3) begin
            return make_req($urandom, $urandom, $urandom, $urandom);
        end else if (sel < 6) begin
            comp[0] = 0;
            comp[1] = 0;
            comp[2] = 0;
            comp[$urandom_range(0, 2)] = $urandom_range(0, 1) ? 16384 : -16384;
            return make_req($urandom, comp[0], comp[1], comp[2]);
        end
        return make_req($urandom, $urandom_range(0, 18918) - 9459,
                        $urandom_range(0, 18918) - 9459, $urandom_range(0, 18918) - 9459);
    endfunction

    // driver: presents the head of the request queue and drives pop at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (push_gap > 0) begin
                push_gap <= push_gap - 1;
                push <= 1'b0;
            end else if (!calm_phase && !hold_push && $urandom_range(0, 15) == 0) begin
                push_gap <= $urandom_range(0, 7);
                push <= 1'b0;
            end else if (!hold_push && req_queue.size() > 0) begin
                push <= 1'b1;
                i_angle <= req_queue[0].angle;
                i_axis_x <= req_queue[0].ax;
                i_axis_y <= req_queue[0].ay;
                i_axis_z <= req_queue[0].az;
            end else begin
                push <= 1'b0;
            end
            if (pop_gap > 0) begin
                pop_gap <= pop_gap - 1;
                pop <= 1'b0;
            end else if (!calm_phase && $urandom_range(0, 15) == 0) begin
                pop_gap <= $urandom_range(0, 7);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // monitor: predict on accepted requests, check accepted matrices
    always @(posedge i_clk) begin
        t_matrix want;
        t_rot_req rq;
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (push && !full) begin
                rq.angle = i_angle;
                rq.ax = i_axis_x;
                rq.ay = i_axis_y;
                rq.az = i_axis_z;
                matrix_queue.push_back(rotation_matrix(rq));
                void'(req_queue.pop_front());
                n_sent++;
            end
            if (pop && !empty) begin
                if (matrix_queue.size() == 0) begin
                    n_errors++;
                    $display("unexpected transaction at %0t", $time);
                end else begin
                    want = matrix_queue.pop_front();
                    n_checked++;
                    if (o_m00 !== want.m00) report_mismatch("m00", o_m00, want.m00);
                    if (o_m01 !== want.m01) report_mismatch("m01", o_m01, want.m01);
                    if (o_m02 !== want.m02) report_mismatch("m02", o_m02, want.m02);
                    if (o_m10 !== want.m10) report_mismatch("m10", o_m10, want.m10);
                    if (o_m11 !== want.m11) report_mismatch("m11", o_m11, want.m11);
                    if (o_m12 !== want.m12) report_mismatch("m12", o_m12, want.m12);
                    if (o_m20 !== want.m20) report_mismatch("m20", o_m20, want.m20);
                    if (o_m21 !== want.m21) report_mismatch("m21", o_m21, want.m21);
                    if (o_m22 !== want.m22) report_mismatch("m22", o_m22, want.m22);
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int n_first;
        // directed: angle extremes, quadrant folds, unit axes, non-unit and out-of-range axes
        req_queue.push_back(make_req(0, 16384, 0, 0));
        req_queue.push_back(make_req(0, 0, 0, 16384));
        req_queue.push_back(make_req(32767, 0, 16384, 0));
        req_queue.push_back(make_req(-32768, 0, 0, 16384));
        req_queue.push_back(make_req(25736, 0, 0, 16384));   // just above pi
        req_queue.push_back(make_req(-25736, 16384, 0, 0));  // just below -pi
        req_queue.push_back(make_req(12868, 0, 0, 16384));   // just above pi/2
        req_queue.push_back(make_req(-12868, 0, 16384, 0));  // just below -pi/2
        req_queue.push_back(make_req(12867, 0, 0, -16384));
        req_queue.push_back(make_req(6434, 9459, 9459, 9459));
        req_queue.push_back(make_req(-6434, -9459, 9459, -9459));
        req_queue.push_back(make_req(20000, 16384, 16384, 16384));   // non-unit axis
        req_queue.push_back(make_req(-20000, -16384, -16384, -16384));
        req_queue.push_back(make_req(1000, -32768, -32768, -32768)); // most negative axis components
        req_queue.push_back(make_req(-1000, 32767, -32768, 32767));
        req_queue.push_back(make_req(25735, -1, -1, -1));
        req_queue.push_back(make_req(-1, 21845, -10923, 10922));
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait (req_queue.size() == 0);
        // hold off until the block has drained completely
        hold_push = 1'b1;
        wait (matrix_queue.size() == 0);
        hold_push = 1'b0;
        n_first = N_RANDOM * 3 / 4;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 2) begin
                wait (req_queue.size() == 0);
                hold_push = 1'b1;
                wait (matrix_queue.size() == 0);
                hold_push = 1'b0;
            end
            if (i == n_first) begin
                wait (req_queue.size() == 0);
                calm_phase = 1'b1;
            end
            req_queue.push_back(random_req());
            if (req_queue.size() > 64) wait (req_queue.size() < 32);
        end
        wait (req_queue.size() == 0 && matrix_queue.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d transactions, %0d matrices checked: folds, saturation,",
                 n_sent, n_checked);
        $display("random angles and axes with bursts of idling on both sides");
        if (n_errors == 0 && matrix_queue.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
